/* rtl/pwdt_pkg.sv */
// ----------------------------------------------------------------------------
// Per-thread watchdog table package
// Request codes, widths of the fixed item fields and table control bundle.
// ----------------------------------------------------------------------------
package pwdt_pkg;

    localparam int CHANNEL_W = 3;
    localparam int TICKS_W   = 16;

    typedef enum logic [1:0] {
        REQ_TICK   = 2'd0,
        REQ_SET    = 2'd1,
        REQ_ENABLE = 2'd2,
        REQ_KICK   = 2'd3
    } pwdt_req_t;

    typedef struct packed {
        logic to_we;
        logic cd_we;
        logic en_we;
    } pwdt_tbl_ctl_t;

endpackage

/* rtl/pwdt_table.sv */
// ----------------------------------------------------------------------------
// Watchdog channel table
// Timeout and countdown memories with row valid bits, plus enable bits.
// One write address and one registered read address per cycle.
// ----------------------------------------------------------------------------
module pwdt_table #(
    parameter int NUM_CHANNELS = 8,
    parameter int COUNT_WIDTH  = 16,
    parameter int IDX_W        = 3
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  pwdt_pkg::pwdt_tbl_ctl_t   ctl,
    input  logic [IDX_W-1:0]          wr_addr,
    input  logic [COUNT_WIDTH-1:0]    to_wdata,
    input  logic [COUNT_WIDTH-1:0]    cd_wdata,
    input  logic [IDX_W-1:0]          rd_addr,
    output logic [COUNT_WIDTH-1:0]    rd_timeout,
    output logic [COUNT_WIDTH-1:0]    rd_countdown,
    output logic                      rd_enable
);

    logic [COUNT_WIDTH-1:0] to_mem [NUM_CHANNELS];
    logic [COUNT_WIDTH-1:0] cd_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] row_ok_reg;
    logic [NUM_CHANNELS-1:0] en_reg;
    logic [COUNT_WIDTH-1:0] rd_to_reg;
    logic [COUNT_WIDTH-1:0] rd_cd_reg;
    logic                   rd_ok_reg;
    logic                   rd_en_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.to_we)
        begin
            to_mem[wr_addr] <= to_wdata;
        end
        if (ctl.cd_we)
        begin
            cd_mem[wr_addr] <= cd_wdata;
        end
        rd_to_reg <= to_mem[rd_addr];
        rd_cd_reg <= cd_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_ok_reg <= '0;
            en_reg     <= '0;
            rd_ok_reg  <= 1'b0;
            rd_en_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.to_we)
            begin
                row_ok_reg[wr_addr] <= 1'b1;
            end
            if (ctl.en_we)
            begin
                en_reg[wr_addr] <= 1'b1;
            end
            rd_ok_reg <= row_ok_reg[rd_addr];
            rd_en_reg <= en_reg[rd_addr];
        end
    end

    // rows never set read as zero
    assign rd_timeout   = rd_ok_reg ? rd_to_reg : '0;
    assign rd_countdown = rd_ok_reg ? rd_cd_reg : '0;
    assign rd_enable    = rd_en_reg;

endmodule

/* rtl/pwdt_seq.sv */
// ----------------------------------------------------------------------------
// Watchdog request sequencer
// Decodes accepted items and walks the table through one shared
// compare-and-decrement unit, one channel per cycle.
// ----------------------------------------------------------------------------
module pwdt_seq #(
    parameter int NUM_CHANNELS = 8,
    parameter int COUNT_WIDTH  = 16,
    parameter int IDX_W        = 3
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  pwdt_pkg::pwdt_req_t       req,
    input  logic [IDX_W-1:0]          ch_idx,
    input  logic                      ch_ok,
    input  logic [COUNT_WIDTH-1:0]    ticks,
    output logic                      idle,
    output pwdt_pkg::pwdt_tbl_ctl_t   ctl,
    output logic [IDX_W-1:0]          wr_addr,
    output logic [COUNT_WIDTH-1:0]    to_wdata,
    output logic [COUNT_WIDTH-1:0]    cd_wdata,
    output logic [IDX_W-1:0]          rd_addr,
    input  logic [COUNT_WIDTH-1:0]    rd_timeout,
    input  logic [COUNT_WIDTH-1:0]    rd_countdown,
    input  logic                      rd_enable,
    output logic                      res_valid,
    output logic                      res_value,
    input  logic                      res_take
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_KICK = 4'b0010,
        S_WALK = 4'b0100,
        S_DONE = 4'b1000
    } seq_state_t;

    seq_state_t       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             res_reg, res_next;

    logic                   last;
    logic                   fail;
    logic [COUNT_WIDTH-1:0] dec;

    // shared check unit
    assign last = (idx_reg == IDX_W'(NUM_CHANNELS - 1));
    assign fail = rd_enable && ((rd_countdown == '0) || (rd_countdown > rd_timeout));
    assign dec  = rd_countdown - COUNT_WIDTH'(1);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        res_next   = res_reg;
        ctl        = '0;
        wr_addr    = idx_reg;
        to_wdata   = ticks;
        cd_wdata   = dec;
        rd_addr    = '0;
        case (state_reg)
            S_IDLE:
            begin
                wr_addr  = ch_idx;
                cd_wdata = ticks;
                rd_addr  = (req == pwdt_pkg::REQ_KICK && ch_ok) ? ch_idx : '0;
                if (start)
                begin
                    case (req)
                        pwdt_pkg::REQ_TICK:
                        begin
                            idx_next   = '0;
                            state_next = S_WALK;
                        end
                        pwdt_pkg::REQ_SET:
                        begin
                            ctl.to_we = ch_ok;
                            ctl.cd_we = ch_ok;
                        end
                        pwdt_pkg::REQ_ENABLE:
                        begin
                            ctl.en_we = ch_ok;
                        end
                        pwdt_pkg::REQ_KICK:
                        begin
                            if (ch_ok)
                            begin
                                idx_next   = ch_idx;
                                state_next = S_KICK;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_KICK:
            begin
                cd_wdata   = rd_timeout;
                ctl.cd_we  = 1'b1;
                state_next = S_IDLE;
            end
            S_WALK:
            begin
                rd_addr = last ? '0 : idx_reg + IDX_W'(1);
                if (fail)
                begin
                    res_next   = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    ctl.cd_we = rd_enable;
                    if (last)
                    begin
                        res_next   = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            res_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            res_reg   <= res_next;
        end
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res_value = res_reg;

endmodule

/* rtl/per_thread_watchdog_table_unit.sv */
// ----------------------------------------------------------------------------
// Per-thread watchdog table unit
// Multi-channel software watchdog: set, enable and kick per channel, and a
// tick that walks the channels up to the first failing one and reports
// whether the hardware watchdog may be reloaded.
// ----------------------------------------------------------------------------
// Set, enable and kick items give no result. A tick: the sequencer walks the
// channel table one entry per cycle from index 0 through a single
// compare-and-decrement unit, reading the registered-output table memory one
// entry ahead, and stops at the first failing enabled channel. The tick's
// hw_reload item is then held in an output register, so the next item can
// be taken while it waits; a further tick walks the table but then holds its
// result, and the input, until that register is free.
// ----------------------------------------------------------------------------
module per_thread_watchdog_table_unit #(
    parameter int NUM_CHANNELS = 8,
    parameter int COUNT_WIDTH  = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic [1:0]                      req_type,
    input  logic [pwdt_pkg::CHANNEL_W-1:0]  channel,
    input  logic [pwdt_pkg::TICKS_W-1:0]    timeout_ticks,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output logic                            hw_reload
);

    localparam int IDX_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CH_EXT_W = (IDX_W > pwdt_pkg::CHANNEL_W) ? IDX_W : pwdt_pkg::CHANNEL_W;
    localparam int TK_EXT_W = (COUNT_WIDTH > pwdt_pkg::TICKS_W) ? COUNT_WIDTH
                                                                 : pwdt_pkg::TICKS_W;

    logic                      idle;
    logic                      start;
    logic [CH_EXT_W-1:0]       ch_ext;
    logic [TK_EXT_W-1:0]       tk_ext;
    logic                      ch_ok;
    pwdt_pkg::pwdt_tbl_ctl_t   ctl;
    logic [IDX_W-1:0]          wr_addr;
    logic [COUNT_WIDTH-1:0]    to_wdata;
    logic [COUNT_WIDTH-1:0]    cd_wdata;
    logic [IDX_W-1:0]          rd_addr;
    logic [COUNT_WIDTH-1:0]    rd_timeout;
    logic [COUNT_WIDTH-1:0]    rd_countdown;
    logic                      rd_enable;
    logic                      res_valid;
    logic                      res_value;
    logic                      res_take;
    logic                      rsp_valid_reg;
    logic                      hw_reload_reg;

    assign req_stall = !idle;
    assign start     = req_valid && idle;
    assign ch_ext    = CH_EXT_W'(channel);
    assign tk_ext    = TK_EXT_W'(timeout_ticks);
    assign ch_ok     = (32'(channel) < 32'(NUM_CHANNELS));
    assign res_take  = !rsp_valid_reg || !rsp_stall;

    pwdt_seq #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .COUNT_WIDTH  (COUNT_WIDTH),
        .IDX_W        (IDX_W)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .req          (pwdt_pkg::pwdt_req_t'(req_type)),
        .ch_idx       (ch_ext[IDX_W-1:0]),
        .ch_ok        (ch_ok),
        .ticks        (tk_ext[COUNT_WIDTH-1:0]),
        .idle         (idle),
        .ctl          (ctl),
        .wr_addr      (wr_addr),
        .to_wdata     (to_wdata),
        .cd_wdata     (cd_wdata),
        .rd_addr      (rd_addr),
        .rd_timeout   (rd_timeout),
        .rd_countdown (rd_countdown),
        .rd_enable    (rd_enable),
        .res_valid    (res_valid),
        .res_value    (res_value),
        .res_take     (res_take)
    );

    pwdt_table #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .COUNT_WIDTH  (COUNT_WIDTH),
        .IDX_W        (IDX_W)
    ) u_table (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .wr_addr      (wr_addr),
        .to_wdata     (to_wdata),
        .cd_wdata     (cd_wdata),
        .rd_addr      (rd_addr),
        .rd_timeout   (rd_timeout),
        .rd_countdown (rd_countdown),
        .rd_enable    (rd_enable)
    );

    // hold the result item until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            hw_reload_reg <= 1'b0;
        end
        else if (res_take)
        begin
            rsp_valid_reg <= res_valid;
            hw_reload_reg <= res_value;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign hw_reload = hw_reload_reg;

endmodule

/* dv/per_thread_watchdog_table_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Per-thread watchdog table unit testbench
// Drives set, enable, kick and tick items with random gaps and output stalls.
// A mirror of the channel tables predicts each tick's hw_reload item, and
// every returned item is compared in order against that prediction.
// ----------------------------------------------------------------------------
module per_thread_watchdog_table_unit_tb;

    localparam int NUM_CHANNELS = 8;
    localparam int COUNT_WIDTH  = 16;
    localparam int RANDOM_ITEMS = 480;
    localparam int CYCLE_LIMIT  = 400000;

    logic                            clk;
    logic                            rst_n;
    logic                            req_valid;
    logic                            req_stall;
    logic [1:0]                      req_type;
    logic [pwdt_pkg::CHANNEL_W-1:0]  channel;
    logic [pwdt_pkg::TICKS_W-1:0]    timeout_ticks;
    logic                            rsp_valid;
    logic                            rsp_stall;
    logic                            hw_reload;

    logic [COUNT_WIDTH-1:0] timeout_mirror   [NUM_CHANNELS];
    logic [COUNT_WIDTH-1:0] countdown_mirror [NUM_CHANNELS];
    logic                   enabled_mirror   [NUM_CHANNELS];

    logic expected_reload [$];
    int   mismatches  = 0;
    int   cycle_count = 0;
    bit   req_steady  = 1'b0;
    bit   rsp_steady  = 1'b0;

    per_thread_watchdog_table_unit #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req_type      (req_type),
        .channel       (channel),
        .timeout_ticks (timeout_ticks),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .hw_reload     (hw_reload)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic walk_channels();
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            if (!enabled_mirror[i])
                continue;
            if (countdown_mirror[i] == '0 || countdown_mirror[i] > timeout_mirror[i])
                return 1'b0;
            countdown_mirror[i] = countdown_mirror[i] - 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic void apply_request(pwdt_pkg::pwdt_req_t kind,
                                          logic [pwdt_pkg::CHANNEL_W-1:0] ch,
                                          logic [pwdt_pkg::TICKS_W-1:0] ticks);
        if (kind == pwdt_pkg::REQ_TICK)
        begin
            expected_reload.push_back(walk_channels());
            return;
        end
        if (ch >= NUM_CHANNELS)
            return;
        case (kind)
            pwdt_pkg::REQ_SET:
            begin
                timeout_mirror[ch]   = ticks[COUNT_WIDTH-1:0];
                countdown_mirror[ch] = ticks[COUNT_WIDTH-1:0];
            end
            pwdt_pkg::REQ_ENABLE: enabled_mirror[ch] = 1'b1;
            default:              countdown_mirror[ch] = timeout_mirror[ch];
        endcase
    endfunction

    task automatic send_request(pwdt_pkg::pwdt_req_t kind,
                                logic [pwdt_pkg::CHANNEL_W-1:0] ch,
                                logic [pwdt_pkg::TICKS_W-1:0] ticks);
        int   gap;
        logic stalled;
        if ($urandom_range(0, 39) == 0)
            req_steady = !req_steady;
        gap = req_steady ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid     <= 1'b1;
        req_type      <= kind;
        channel       <= ch;
        timeout_ticks <= ticks;
        do
        begin
            @(negedge clk);
            stalled = req_stall;
            @(posedge clk);
        end
        while (stalled !== 1'b0);
        apply_request(kind, ch, ticks);
    endtask

    // hold off, release, then take one hw_reload item
    initial
    begin
        int   hold;
        logic seen_valid;
        logic seen_reload;
        logic want;
        rsp_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 29) == 0)
                rsp_steady = !rsp_steady;
            hold = rsp_steady ? 0 : $urandom_range(0, 17);
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do
            begin
                @(negedge clk);
                seen_valid  = rsp_valid;
                seen_reload = hw_reload;
                @(posedge clk);
            end
            while (seen_valid !== 1'b1);
            if (expected_reload.size() == 0)
            begin
                $error("hw_reload: expected no item, actual %0b", seen_reload);
                mismatches++;
            end
            else
            begin
                want = expected_reload.pop_front();
                if (seen_reload !== want)
                begin
                    $error("hw_reload: expected %0b, actual %0b", want, seen_reload);
                    mismatches++;
                end
            end
        end
    end

    task automatic test_idle_ticks();
        send_request(pwdt_pkg::REQ_TICK, 3'd0, 16'h0000);
        send_request(pwdt_pkg::REQ_TICK, 3'd7, 16'hFFFF);
    endtask

    task automatic test_zero_timeout();
        send_request(pwdt_pkg::REQ_ENABLE, 3'd0, 16'h0000);
        send_request(pwdt_pkg::REQ_TICK, 3'd0, 16'h0000);
        send_request(pwdt_pkg::REQ_TICK, 3'd5, 16'hA5A5);
    endtask

    task automatic test_countdown_walk();
        send_request(pwdt_pkg::REQ_SET, 3'd0, 16'd2);
        send_request(pwdt_pkg::REQ_SET, 3'd7, 16'hFFFF);
        send_request(pwdt_pkg::REQ_ENABLE, 3'd7, 16'h0000);
        send_request(pwdt_pkg::REQ_SET, 3'd5, 16'h5555);
        send_request(pwdt_pkg::REQ_TICK, 3'd0, 16'h0000);
        send_request(pwdt_pkg::REQ_TICK, 3'd0, 16'h0000);
        send_request(pwdt_pkg::REQ_TICK, 3'd0, 16'h0000);
        send_request(pwdt_pkg::REQ_KICK, 3'd0, 16'h1234);
        send_request(pwdt_pkg::REQ_TICK, 3'd0, 16'h0000);
    endtask

    task automatic test_failure_stops_walk();
        send_request(pwdt_pkg::REQ_SET, 3'd3, 16'h0000);
        send_request(pwdt_pkg::REQ_ENABLE, 3'd3, 16'h0000);
        send_request(pwdt_pkg::REQ_TICK, 3'd0, 16'h0000);
        send_request(pwdt_pkg::REQ_SET, 3'd3, 16'd1);
        send_request(pwdt_pkg::REQ_TICK, 3'd0, 16'h0000);
        send_request(pwdt_pkg::REQ_TICK, 3'd0, 16'h0000);
        send_request(pwdt_pkg::REQ_KICK, 3'd3, 16'h0000);
        send_request(pwdt_pkg::REQ_TICK, 3'd0, 16'h0000);
    endtask

    task automatic test_random_traffic();
        int                              pick;
        pwdt_pkg::pwdt_req_t             kind;
        logic [pwdt_pkg::TICKS_W-1:0]    ticks;
        logic [pwdt_pkg::CHANNEL_W-1:0]  ch;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                kind = pwdt_pkg::REQ_TICK;
            else if (pick < 55)
                kind = pwdt_pkg::REQ_SET;
            else if (pick < 90)
                kind = pwdt_pkg::REQ_KICK;
            else
                kind = pwdt_pkg::REQ_ENABLE;
            case ($urandom_range(0, 9))
                0:       ticks = pwdt_pkg::TICKS_W'($urandom_range(0, 65535));
                1:       ticks = '0;
                default: ticks = pwdt_pkg::TICKS_W'($urandom_range(1, 24));
            endcase
            ch = pwdt_pkg::CHANNEL_W'($urandom_range(0, NUM_CHANNELS - 1));
            send_request(kind, ch, ticks);
        end
    endtask

    initial
    begin
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            timeout_mirror[i]   = '0;
            countdown_mirror[i] = '0;
            enabled_mirror[i]   = 1'b0;
        end
        rst_n         <= 1'b0;
        req_valid     <= 1'b0;
        req_type      <= pwdt_pkg::REQ_TICK;
        channel       <= '0;
        timeout_ticks <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_ticks();
        test_zero_timeout();
        test_countdown_walk();
        test_failure_stops_walk();
        test_random_traffic();

        req_valid <= 1'b0;
        while (expected_reload.size() != 0)
            @(posedge clk);
        repeat (NUM_CHANNELS + 6) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
